### rtl/assert_macros.svh
// assertion macros shared by the rtl files of the chunk deframer
// expects signals clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never be true while out of reset
`define PCD_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define PCD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/pcd_pkg.sv
// types, constants and the chunk type classifier of the png chunk deframer
// no dependencies
package pcd_pkg;

	// parser phase, one-hot
	typedef enum logic [4:0] {
		PH_SIG  = 5'b00001,
		PH_LEN  = 5'b00010,
		PH_TYPE = 5'b00100,
		PH_DATA = 5'b01000,
		PH_CRC  = 5'b10000
	} phase_t;

	localparam int NUM_KINDS = 24;
	localparam int NUM_CODES = 23;

	localparam logic [4:0] KIND_TEXT    = 5'd16;
	localparam logic [4:0] KIND_IEND    = 5'd22;
	localparam logic [4:0] KIND_UNKNOWN = 5'd23;

	localparam logic [31:0] SIG_LAST     = 32'd7;
	localparam logic [31:0] WIDTH_FIRST  = 32'd16;
	localparam logic [31:0] WIDTH_LAST   = 32'd19;
	localparam logic [31:0] HEIGHT_FIRST = 32'd20;
	localparam logic [31:0] HEIGHT_LAST  = 32'd23;
	localparam logic [1:0]  FIELD_LAST   = 2'd3;

	localparam logic [31:0] ITXT_CODE = 32'h69545874;

	// chunk type codes in kind order
	localparam logic [31:0] TYPE_CODES [NUM_CODES] = '{
		32'h49484452, // IHDR
		32'h6348524D, // cHRM
		32'h67414D41, // gAMA
		32'h69434350, // iCCP
		32'h73424954, // sBIT
		32'h73524742, // sRGB
		32'h504C5445, // PLTE
		32'h624B4744, // bKGD
		32'h68495354, // hIST
		32'h74524E53, // tRNS
		32'h6F464673, // oFFs
		32'h70485973, // pHYs
		32'h73504C54, // sPLT
		32'h7343414C, // sCAL
		32'h49444154, // IDAT
		32'h74494D45, // tIME
		32'h74455874, // tEXt
		32'h7A545874, // zTXt
		32'h66524163, // fRAc
		32'h67494667, // gIFg
		32'h67494674, // gIFt
		32'h67494678, // gIFx
		32'h49454E44  // IEND
	};

	// one finished chunk, handed from the parser to the counter stage
	typedef struct packed {
		logic        clear;
		logic [31:0] offset;
		logic [4:0]  kind;
		logic [31:0] length;
		logic [31:0] crc;
		logic [31:0] width;
		logic [31:0] height;
		logic [31:0] consumed;
	} chunk_rec_t;

	// map a four-character type code to its kind, iTXt shares the text kind
	function automatic logic [4:0] classify(input logic [31:0] code);
		logic [4:0] k;
		k = KIND_UNKNOWN;
		for (int i = 0; i < NUM_CODES; i++) begin
			if (TYPE_CODES[i] == code) k = 5'(i);
		end
		if (code == ITXT_CODE) k = KIND_TEXT;
		return k;
	endfunction

endpackage

### rtl/pcd_in_if.sv
// byte input channel of the png chunk deframer
// no dependencies
interface pcd_in_if;
	logic       valid;
	logic       ready;
	logic       start_req;
	logic [7:0] data_byte;

	modport source(output valid, output start_req, output data_byte, input ready);
	modport sink(input valid, input start_req, input data_byte, output ready);
endinterface

### rtl/pcd_out_if.sv
// chunk record output channel of the png chunk deframer
// no dependencies
interface pcd_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] chunk_offset;
	logic [4:0]  chunk_kind;
	logic [31:0] chunk_length;
	logic [31:0] crc_value;
	logic [31:0] kind_count;
	logic [31:0] image_width;
	logic [31:0] image_height;
	logic [31:0] bytes_consumed;
	logic        is_end;
	logic        is_error;

	modport source(output valid, output chunk_offset, output chunk_kind,
		output chunk_length, output crc_value, output kind_count, output image_width,
		output image_height, output bytes_consumed, output is_end, output is_error,
		input ready);
	modport sink(input valid, input chunk_offset, input chunk_kind,
		input chunk_length, input crc_value, input kind_count, input image_width,
		input image_height, input bytes_consumed, input is_end, input is_error,
		output ready);
endinterface

### rtl/pcd_front.sv
// byte parser: signature skip, header capture, chunk framing and classification
// depends on pcd_pkg, pcd_in_if and assert_macros.svh
`include "assert_macros.svh"

module pcd_front
	import pcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	pcd_in_if.sink     byte_in,
	input  logic       full,
	output logic       push,
	output chunk_rec_t rec
);

	phase_t      phase_q, e_phase, phase_d;
	logic [1:0]  idx_q, e_idx, idx_d;
	logic [31:0] off_q, e_off, off_d;
	logic [31:0] cstart_q, cstart_d;
	logic [31:0] len_q, e_len, len_d;
	logic [31:0] rem_q, rem_d;
	logic [31:0] type_q, e_type, type_d;
	logic [31:0] crc_q, e_crc, crc_d;
	logic [31:0] width_q, e_width, width_d;
	logic [31:0] height_q, e_height, height_d;
	logic [4:0]  kind_q, kind_d;
	logic        stopped_q, e_stopped, stopped_d;
	logic        clr_pend_q, e_clr, clr_d;
	logic        accept, restart;
	logic [7:0]  b;

	assign byte_in.ready = !full;
	assign accept  = byte_in.valid && byte_in.ready;
	assign restart = accept && byte_in.start_req;
	assign b       = byte_in.data_byte;

	// state as seen after an optional restart
	assign e_phase   = restart ? PH_SIG : phase_q;
	assign e_idx     = restart ? 2'd0 : idx_q;
	assign e_off     = restart ? 32'd0 : off_q;
	assign e_len     = restart ? 32'd0 : len_q;
	assign e_type    = restart ? 32'd0 : type_q;
	assign e_crc     = restart ? 32'd0 : crc_q;
	assign e_width   = restart ? 32'd0 : width_q;
	assign e_height  = restart ? 32'd0 : height_q;
	assign e_stopped = restart ? 1'b0 : stopped_q;
	assign e_clr     = restart ? 1'b1 : clr_pend_q;

	// next state for one accepted byte
	always_comb begin
		phase_d   = e_phase;
		idx_d     = e_idx;
		off_d     = e_off;
		cstart_d  = cstart_q;
		len_d     = e_len;
		rem_d     = rem_q;
		type_d    = e_type;
		crc_d     = e_crc;
		width_d   = e_width;
		height_d  = e_height;
		kind_d    = kind_q;
		stopped_d = e_stopped;
		clr_d     = e_clr;
		push      = 1'b0;
		rec       = '0;
		if (!e_stopped) begin
			// header capture by file offset
			if (e_off >= WIDTH_FIRST && e_off <= WIDTH_LAST) begin
				width_d = {e_width[23:0], b};
			end else if (e_off >= HEIGHT_FIRST && e_off <= HEIGHT_LAST) begin
				height_d = {e_height[23:0], b};
			end
			case (e_phase)
				PH_SIG: begin
					if (e_off >= SIG_LAST) begin
						phase_d = PH_LEN;
						idx_d   = 2'd0;
					end
				end
				PH_LEN: begin
					if (e_idx == 2'd0) cstart_d = e_off;
					len_d = {e_len[23:0], b};
					if (e_idx == FIELD_LAST) begin
						idx_d   = 2'd0;
						phase_d = PH_TYPE;
					end else begin
						idx_d = e_idx + 2'd1;
					end
				end
				PH_TYPE: begin
					type_d = {e_type[23:0], b};
					if (e_idx == FIELD_LAST) begin
						idx_d   = 2'd0;
						rem_d   = e_len;
						kind_d  = classify(type_d);
						phase_d = (e_len == 32'd0) ? PH_CRC : PH_DATA;
					end else begin
						idx_d = e_idx + 2'd1;
					end
				end
				PH_DATA: begin
					rem_d = rem_q - 32'd1;
					if (rem_d == 32'd0) begin
						phase_d = PH_CRC;
						idx_d   = 2'd0;
					end
				end
				PH_CRC: begin
					crc_d = {e_crc[23:0], b};
					if (e_idx == FIELD_LAST) begin
						push         = accept;
						rec.clear    = e_clr;
						rec.offset   = cstart_q;
						rec.kind     = kind_q;
						rec.length   = e_len;
						rec.crc      = crc_d;
						rec.width    = width_d;
						rec.height   = height_d;
						rec.consumed = (&e_off) ? e_off : e_off + 32'd1;
						clr_d        = 1'b0;
						if (kind_q == KIND_IEND || kind_q == KIND_UNKNOWN) stopped_d = 1'b1;
						idx_d   = 2'd0;
						len_d   = 32'd0;
						type_d  = 32'd0;
						crc_d   = 32'd0;
						phase_d = PH_LEN;
					end else begin
						idx_d = e_idx + 2'd1;
					end
				end
				default: begin
					phase_d = PH_SIG;
				end
			endcase
			if (!(&e_off)) off_d = e_off + 32'd1;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SIG;
			idx_q      <= 2'd0;
			off_q      <= 32'd0;
			len_q      <= 32'd0;
			type_q     <= 32'd0;
			crc_q      <= 32'd0;
			width_q    <= 32'd0;
			height_q   <= 32'd0;
			stopped_q  <= 1'b0;
			clr_pend_q <= 1'b0;
		end else if (accept) begin
			phase_q    <= phase_d;
			idx_q      <= idx_d;
			off_q      <= off_d;
			len_q      <= len_d;
			type_q     <= type_d;
			crc_q      <= crc_d;
			width_q    <= width_d;
			height_q   <= height_d;
			stopped_q  <= stopped_d;
			clr_pend_q <= clr_d;
		end
	end

	// payload registers, always written before being read
	always_ff @(posedge clk) begin
		if (accept) begin
			cstart_q <= cstart_d;
			rem_q    <= rem_d;
			kind_q   <= kind_d;
		end
	end

	`PCD_ASSERT_IMPL(a_push_in_crc, push, phase_q == PH_CRC && idx_q == FIELD_LAST, "push outside last crc byte")
	`PCD_ASSERT_NEVER(a_push_stopped, push && stopped_q, "record pushed while stopped")

endmodule

### rtl/pcd_fifo.sv
// short queue of finished chunk transactions between parser and counter stage
// depends on pcd_pkg and assert_macros.svh
`include "assert_macros.svh"

module pcd_fifo
	import pcd_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  chunk_rec_t wr_rec,
	input  logic       pop,
	output chunk_rec_t rd_rec,
	output logic       full,
	output logic       empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

	chunk_rec_t      slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign rd_rec = slot_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop) count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= wr_rec;
	end

	`PCD_ASSERT_NEVER(a_overflow, push && full, "push into full queue")
	`PCD_ASSERT_NEVER(a_underflow, pop && empty, "pop from empty queue")

endmodule

### rtl/pcd_back.sv
// per-kind saturating counters and the registered output record
// depends on pcd_pkg, pcd_out_if and assert_macros.svh
`include "assert_macros.svh"

module pcd_back
	import pcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  chunk_rec_t rec,
	input  logic       empty,
	output logic       pop,
	pcd_out_if.source  rec_out
);

	logic [31:0] cnt_q [NUM_KINDS];
	logic [31:0] cnt_base, cnt_new;
	logic        out_valid_q;
	chunk_rec_t  rec_s1;
	logic [31:0] count_s1;

	assign pop = !empty && (!out_valid_q || rec_out.ready);

	// counter update, a start transaction clears the table first
	assign cnt_base = rec.clear ? 32'd0 : cnt_q[rec.kind];
	assign cnt_new  = (&cnt_base) ? cnt_base : cnt_base + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_KINDS; i++) cnt_q[i] <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				for (int i = 0; i < NUM_KINDS; i++) begin
					if (rec.kind == 5'(i)) cnt_q[i] <= cnt_new;
					else if (rec.clear) cnt_q[i] <= 32'd0;
				end
				out_valid_q <= 1'b1;
			end else if (rec_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output record register
	always_ff @(posedge clk) begin
		if (pop) begin
			rec_s1   <= rec;
			count_s1 <= cnt_new;
		end
	end

	assign rec_out.valid          = out_valid_q;
	assign rec_out.chunk_offset   = rec_s1.offset;
	assign rec_out.chunk_kind     = rec_s1.kind;
	assign rec_out.chunk_length   = rec_s1.length;
	assign rec_out.crc_value      = rec_s1.crc;
	assign rec_out.kind_count     = count_s1;
	assign rec_out.image_width    = rec_s1.width;
	assign rec_out.image_height   = rec_s1.height;
	assign rec_out.bytes_consumed = rec_s1.consumed;
	assign rec_out.is_end         = (rec_s1.kind == KIND_IEND);
	assign rec_out.is_error       = (rec_s1.kind == KIND_UNKNOWN);

	`PCD_ASSERT_IMPL(a_count_nonzero, out_valid_q, count_s1 != 32'd0, "record with zero count")
	`PCD_ASSERT_NEVER(a_end_and_error, out_valid_q && rec_out.is_end && rec_out.is_error, "end and error together")

endmodule

### rtl/png_chunk_deframer_counter_unit.sv
// PNG chunk deframer and per-kind chunk counter, top level
//
// byte_in carries one file byte per transaction; start_req on a byte clears
// all parser state and the kind counters, and that byte is file offset 0.
// rec_out carries one record per chunk, sent after the chunk's last CRC byte:
// offset, kind, length, stored CRC, saturating kind count, captured width and
// height, bytes consumed and the end and error flags.
// The parser takes one byte per cycle while the queue is not full. A record
// passes from the queue, which takes it as its last CRC byte is accepted, to the
// output register; the counter stage retires one record per cycle while that
// register is empty or being taken, so chunks follow each other without gaps.
// After IEND or an unknown chunk type, bytes are taken and dropped until the
// next start_req.
// When rec_out stalls, records collect in the queue (QUEUE_DEPTH entries) plus
// the output register; only when the queue is full does byte_in drop ready.
// Reset clears the parser, the counters and the queue; the first byte after
// reset is treated as offset 0 even without start_req.
// depends on pcd_pkg, pcd_in_if, pcd_out_if, pcd_front, pcd_fifo, pcd_back
module png_chunk_deframer_counter_unit
	import pcd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	pcd_in_if.sink    byte_in,
	pcd_out_if.source rec_out
);

	chunk_rec_t front_rec, queue_rec;
	logic       push, pop, full, empty;

	// parser and classifier
	pcd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_in),
		.full    (full),
		.push    (push),
		.rec     (front_rec)
	);

	// decoupling queue
	pcd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (front_rec),
		.pop    (pop),
		.rd_rec (queue_rec),
		.full   (full),
		.empty  (empty)
	);

	// counters and output register
	pcd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.rec     (queue_rec),
		.empty   (empty),
		.pop     (pop),
		.rec_out (rec_out)
	);

endmodule

### bench/tb_png_chunk_deframer_counter_unit.sv
// testbench for png_chunk_deframer_counter_unit: png-shaped byte streams in,
// chunk records checked against a transaction-level model kept in a small checker class
// depends on pcd_pkg, pcd_in_if, pcd_out_if and the rtl top level
`timescale 1ns / 100ps

module tb_png_chunk_deframer_counter_unit;
	import pcd_pkg::*;

	localparam int unsigned RX_HOLD_CYCLES = 400;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES   = 16;
	localparam int unsigned REPORT_LIMIT   = 10;

	// file layout as the parser sees it
	localparam logic [31:0] SIGNATURE_END = 32'd7;
	localparam logic [31:0] WIDTH_AT      = 32'd16;
	localparam logic [31:0] HEIGHT_AT     = 32'd20;
	localparam logic [1:0]  FIELD_END     = 2'd3;

	localparam logic [7:0] PNG_SIGNATURE [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
		8'h0D, 8'h0A, 8'h1A, 8'h0A};

	// every known type except IEND, so a file keeps going after one
	localparam logic [31:0] MID_CODES [23] = '{"IHDR", "cHRM", "gAMA", "iCCP", "sBIT",
		"sRGB", "PLTE", "bKGD", "hIST", "tRNS", "oFFs", "pHYs", "sPLT", "sCAL", "IDAT",
		"tIME", "tEXt", "iTXt", "zTXt", "fRAc", "gIFg", "gIFt", "gIFx"};

	// near misses of real type codes, all unknown
	localparam logic [31:0] ODD_CODES [6] = '{"tEXT", "OFFs", "sCAl", "gIFG", "IENd", "ihdr"};

	typedef enum logic [4:0] {
		K_IHDR, K_CHRM, K_GAMA, K_ICCP, K_SBIT, K_SRGB, K_PLTE, K_BKGD, K_HIST, K_TRNS,
		K_OFFS, K_PHYS, K_SPLT, K_SCAL, K_IDAT, K_TIME, K_TEXT, K_ZTXT, K_FRAC, K_GIFG,
		K_GIFT, K_GIFX, K_IEND, K_UNKNOWN
	} chunk_kind_e;

	typedef struct packed {
		logic [31:0] offset;
		logic [4:0]  kind;
		logic [31:0] length;
		logic [31:0] crc;
		logic [31:0] count;
		logic [31:0] width;
		logic [31:0] height;
		logic [31:0] consumed;
		logic        is_end;
		logic        is_error;
	} chunk_record_t;

	// tracks the parser state per accepted byte and holds the chunk records still owed
	class chunk_ledger;
		phase_t        parse_phase;
		logic [1:0]    field_idx;
		logic [31:0]   file_off;
		logic [31:0]   chunk_base;
		logic [31:0]   len_acc;
		logic [31:0]   data_left;
		logic [31:0]   code_acc;
		logic [31:0]   crc_acc;
		logic [31:0]   width_acc;
		logic [31:0]   height_acc;
		logic [31:0]   kind_tally [NUM_KINDS];
		bit            halted;
		chunk_record_t awaited_records[$];
		int unsigned   error_count;

		function new();
			clear();
			error_count = 0;
		endfunction

		function void clear();
			parse_phase = PH_SIG;
			field_idx = '0;
			file_off = '0;
			chunk_base = '0;
			len_acc = '0;
			data_left = '0;
			code_acc = '0;
			crc_acc = '0;
			width_acc = '0;
			height_acc = '0;
			foreach (kind_tally[i]) kind_tally[i] = '0;
			halted = 1'b0;
		endfunction

		function chunk_kind_e kind_of(logic [31:0] code);
			case (code)
			"IHDR": return K_IHDR;
			"cHRM": return K_CHRM;
			"gAMA": return K_GAMA;
			"iCCP": return K_ICCP;
			"sBIT": return K_SBIT;
			"sRGB": return K_SRGB;
			"PLTE": return K_PLTE;
			"bKGD": return K_BKGD;
			"hIST": return K_HIST;
			"tRNS": return K_TRNS;
			"oFFs": return K_OFFS;
			"pHYs": return K_PHYS;
			"sPLT": return K_SPLT;
			"sCAL": return K_SCAL;
			"IDAT": return K_IDAT;
			"tIME": return K_TIME;
			"tEXt": return K_TEXT;
			"iTXt": return K_TEXT;
			"zTXt": return K_ZTXT;
			"fRAc": return K_FRAC;
			"gIFg": return K_GIFG;
			"gIFt": return K_GIFT;
			"gIFx": return K_GIFX;
			"IEND": return K_IEND;
			default: return K_UNKNOWN;
			endcase
		endfunction

		function void take_byte(bit first, logic [7:0] b);
			logic [31:0]   off;
			chunk_kind_e   k;
			chunk_record_t rec;
			if (first) clear();
			// after IEND or an unknown type nothing moves until the next start
			if (halted) return;
			off = file_off;

			// width and height go by file offset, whatever the chunk layout
			if (off >= WIDTH_AT && off < WIDTH_AT + 4) begin
				width_acc = {width_acc[23:0], b};
			end else if (off >= HEIGHT_AT && off < HEIGHT_AT + 4) begin
				height_acc = {height_acc[23:0], b};
			end

			case (parse_phase)
			PH_SIG: begin
				if (off >= SIGNATURE_END) begin
					parse_phase = PH_LEN;
					field_idx = '0;
				end
			end
			PH_LEN: begin
				if (field_idx == 2'd0) chunk_base = off;
				len_acc = {len_acc[23:0], b};
				if (field_idx == FIELD_END) begin
					field_idx = '0;
					parse_phase = PH_TYPE;
				end else begin
					field_idx++;
				end
			end
			PH_TYPE: begin
				code_acc = {code_acc[23:0], b};
				if (field_idx == FIELD_END) begin
					field_idx = '0;
					data_left = len_acc;
					parse_phase = (len_acc == '0) ? PH_CRC : PH_DATA;
				end else begin
					field_idx++;
				end
			end
			PH_DATA: begin
				data_left--;
				if (data_left == '0) begin
					parse_phase = PH_CRC;
					field_idx = '0;
				end
			end
			PH_CRC: begin
				crc_acc = {crc_acc[23:0], b};
				if (field_idx == FIELD_END) begin
					// last crc byte closes the chunk
					k = kind_of(code_acc);
					if (kind_tally[k] != '1) kind_tally[k]++;
					rec.offset = chunk_base;
					rec.kind = k;
					rec.length = len_acc;
					rec.crc = crc_acc;
					rec.count = kind_tally[k];
					rec.width = width_acc;
					rec.height = height_acc;
					rec.consumed = (off == '1) ? off : off + 1;
					rec.is_end = (k == K_IEND);
					rec.is_error = (k == K_UNKNOWN);
					awaited_records.push_back(rec);
					if (k == K_IEND || k == K_UNKNOWN) halted = 1'b1;
					field_idx = '0;
					len_acc = '0;
					code_acc = '0;
					crc_acc = '0;
					parse_phase = PH_LEN;
				end else begin
					field_idx++;
				end
			end
			default: ;
			endcase

			if (file_off != '1) file_off++;
		endfunction

		function void note_error(string msg);
			error_count++;
			if (error_count <= REPORT_LIMIT) $display("mismatch: %s", msg);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) note_error($sformatf("%s expected %0h actual %0h", name, want, got));
		endfunction

		function void match_record(chunk_record_t got);
			chunk_record_t want;
			if (awaited_records.size() == 0) begin
				note_error($sformatf("record for offset %0h with none expected", got.offset));
				return;
			end
			want = awaited_records.pop_front();
			compare_field("chunk_offset", want.offset, got.offset);
			compare_field("chunk_kind", want.kind, got.kind);
			compare_field("chunk_length", want.length, got.length);
			compare_field("crc_value", want.crc, got.crc);
			compare_field("kind_count", want.count, got.count);
			compare_field("image_width", want.width, got.width);
			compare_field("image_height", want.height, got.height);
			compare_field("bytes_consumed", want.consumed, got.consumed);
			compare_field("is_end", want.is_end, got.is_end);
			compare_field("is_error", want.is_error, got.is_error);
		endfunction

		function int unsigned pending();
			return awaited_records.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	pcd_in_if  byte_in();
	pcd_out_if rec_out();

	png_chunk_deframer_counter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_in(byte_in),
		.rec_out(rec_out)
	);

	chunk_ledger ledger;
	int unsigned tx_idle_pct;
	int unsigned rx_stall_pct;
	int unsigned hold_requests;
	int unsigned bytes_sent;

	// 50 MHz clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// byte transactions feed the model
	always @(posedge clk) begin
		if (arst_n && byte_in.valid && byte_in.ready) begin
			ledger.take_byte(byte_in.start_req, byte_in.data_byte);
		end
	end

	// record transactions are checked against the oldest expectation
	always @(posedge clk) begin : record_monitor
		chunk_record_t got;
		if (arst_n && rec_out.valid && rec_out.ready) begin
			got.offset = rec_out.chunk_offset;
			got.kind = rec_out.chunk_kind;
			got.length = rec_out.chunk_length;
			got.crc = rec_out.crc_value;
			got.count = rec_out.kind_count;
			got.width = rec_out.image_width;
			got.height = rec_out.image_height;
			got.consumed = rec_out.bytes_consumed;
			got.is_end = rec_out.is_end;
			got.is_error = rec_out.is_error;
			ledger.match_record(got);
		end
	end

	// record sink: random stalls, plus a long hold-off on request
	initial begin : receiver
		int unsigned holds_done;
		holds_done = 0;
		rec_out.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done != hold_requests) begin
				rec_out.ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else begin
				rec_out.ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// ends the run when neither channel moves for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((byte_in.valid && byte_in.ready) || (rec_out.valid && rec_out.ready)) quiet = 0;
			else quiet++;
		end
		$display("png_chunk_deframer_counter_unit test failed");
		$finish;
	end

	// one byte transaction, with random idle cycles ahead of it
	task automatic send_byte(input bit first, input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			byte_in.valid <= 1'b0;
			@(posedge clk);
		end
		byte_in.valid <= 1'b1;
		byte_in.start_req <= first;
		byte_in.data_byte <= b;
		@(posedge clk);
		while (!byte_in.ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic put_word(input logic [31:0] w);
		for (int i = 3; i >= 0; i--) send_byte(1'b0, w[i*8 +: 8]);
	endtask

	task automatic send_signature(input bit first, input bit genuine);
		for (int i = 0; i < 8; i++) begin
			send_byte(first && i == 0, genuine ? PNG_SIGNATURE[i] : 8'($urandom));
		end
	endtask

	task automatic send_chunk(input logic [31:0] code, input logic [31:0] len,
		input logic [31:0] crc);
		put_word(len);
		put_word(code);
		repeat (len) send_byte(1'b0, 8'($urandom));
		put_word(crc);
	endtask

	task automatic send_ihdr(input logic [31:0] w, input logic [31:0] h);
		put_word(32'd13);
		put_word("IHDR");
		put_word(w);
		put_word(h);
		repeat (5) send_byte(1'b0, 8'($urandom));
		put_word($urandom);
	endtask

	// mostly short chunks, now and then a longer one
	function automatic logic [31:0] pick_length();
		return ($urandom_range(9) == 0) ? $urandom_range(64, 13) : $urandom_range(12);
	endfunction

	// one file: mostly well formed, some noise, truncation and missing starts
	task automatic random_file();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 8) begin
			send_byte(1'b1, 8'($urandom));
			repeat ($urandom_range(40, 3)) send_byte($urandom_range(19) == 0, 8'($urandom));
			return;
		end
		send_signature($urandom_range(19) != 0, $urandom_range(4) != 0);
		if ($urandom_range(9) != 0) send_ihdr($urandom, $urandom);
		repeat ($urandom_range(5)) send_chunk(MID_CODES[$urandom_range(22)], pick_length(),
			$urandom);

		roll = $urandom_range(99);
		if (roll < 55) begin
			send_chunk("IEND", ($urandom_range(9) == 0) ? pick_length() : 32'd0, $urandom);
		end else if (roll < 70) begin
			send_chunk(($urandom_range(1) != 0) ? ODD_CODES[$urandom_range(5)] : 32'($urandom),
				pick_length(), $urandom);
		end else if (roll < 85) begin
			// cut off inside a chunk, the next start abandons it
			put_word(($urandom_range(3) == 0) ? 32'($urandom) : pick_length() + 8);
			put_word(MID_CODES[$urandom_range(22)]);
			repeat ($urandom_range(4)) send_byte(1'b0, 8'($urandom));
		end

		// trailing bytes, dropped once the parser has stopped
		if ($urandom_range(3) == 0) repeat ($urandom_range(6, 1)) send_byte(1'b0, 8'($urandom));
	endtask

	task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct,
		input int unsigned byte_goal);
		int unsigned goal;
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		goal = bytes_sent + byte_goal;
		while (bytes_sent < goal) random_file();
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		byte_in.valid = 1'b0;
		byte_in.start_req = 1'b0;
		byte_in.data_byte = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_requests = 0;
		bytes_sent = 0;
		ledger = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first file right after reset, no start flag, extreme byte values
		for (int i = 0; i < 8; i++) send_byte(1'b0, i[0] ? 8'hFF : 8'h00);
		send_chunk("sRGB", 32'd0, 32'h00000000);
		send_chunk("IEND", 32'd0, 32'hFFFFFFFF);
		send_byte(1'b0, 8'hFF);
		send_byte(1'b0, 8'h00);

		// extreme header values, iTXt shares the text kind, unknown type stops parsing
		send_signature(1'b1, 1'b1);
		send_ihdr(32'hFFFFFFFF, 32'h00000000);
		send_chunk("iTXt", 32'd1, $urandom);
		send_chunk("tEXT", 32'd0, $urandom);
		send_byte(1'b0, 8'($urandom));

		// zero-length chunks: the first ends before the height is captured, the second after
		send_signature(1'b1, 1'b1);
		send_chunk("gAMA", 32'd0, $urandom);
		send_chunk("gAMA", 32'd0, $urandom);

		// huge length field, abandoned by the next start
		send_signature(1'b1, 1'b1);
		put_word(32'hFFFFFFFF);
		put_word("IDAT");
		repeat (3) send_byte(1'b0, 8'($urandom));

		run_phase(0, 0, 180);

		// long receiver hold-off while the sender keeps going
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_requests++;
		send_signature(1'b1, 1'b1);
		repeat (20) send_chunk(MID_CODES[$urandom_range(22)], 32'd0, $urandom);
		send_chunk("IEND", 32'd0, $urandom);

		run_phase(77, 0, 140);
		run_phase(0, 77, 140);

		// sender pause until the block has drained
		byte_in.valid <= 1'b0;
		while (ledger.pending() != 0) @(posedge clk);

		run_phase(11, 11, 140);
		run_phase(0, 0, 50);

		byte_in.valid <= 1'b0;
		while (ledger.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (ledger.error_count == 0) begin
			$display("png_chunk_deframer_counter_unit test passed");
		end else begin
			$display("png_chunk_deframer_counter_unit test failed");
		end
		$finish;
	end
endmodule
